@@ sv/mbrtu_pkg.sv @@
package mbrtu_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int SEC_W       = 22;
  localparam int DIV_W       = 26;
  localparam int APB_ADDR_W  = 4;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  localparam logic [2:0] ST_RESP  = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_CRC   = 3'd3;
  localparam logic [2:0] ST_UNSUP = 3'd4;
  localparam logic [2:0] ST_RANGE = 3'd5;

  localparam logic [1:0] REG_SLAVE   = 2'd0;
  localparam logic [1:0] REG_SILENCE = 2'd1;
  localparam logic [1:0] REG_VREF    = 2'd2;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [9:0]  MS_PER_SEC_M1   = 10'd999;
  localparam logic [10:0] ADC_FULL        = 11'd1023;
  localparam logic [LEN_W-1:0] MIN_FRAME  = LEN_W'(6);
  localparam logic [LEN_W-1:0] REQ_LEN    = LEN_W'(8);
  localparam logic [16:0] NUM_REGS        = 17'd6;

  localparam logic [7:0]  RST_SLAVE   = 8'd1;
  localparam logic [7:0]  RST_SILENCE = 8'd4;
  localparam logic [15:0] RST_VREF    = 16'd5000;

  typedef struct packed {
    logic [7:0]  slave_addr;
    logic [7:0]  silence;
    logic [15:0] vref;
  } cfg_t;

  typedef enum logic {OP_BYTE, OP_FRAME} op_t;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic [15:0]      seconds;
    logic [9:0]       sample0;
    logic [9:0]       sample1;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_READ, B_WAIT, B_CHECK, B_DIV, B_EMIT, B_STAT
  } back_state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/mbrtu_fifo.sv @@
module mbrtu_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mbrtu_pkg::job_t   push_job,
  output logic              full,
  input  logic              pop,
  output mbrtu_pkg::job_t   pop_job,
  output logic              empty
);

  localparam int PTR_W = $clog2(mbrtu_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(mbrtu_pkg::QUEUE_DEPTH + 1);

  mbrtu_pkg::job_t entry_r [mbrtu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(mbrtu_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(mbrtu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(mbrtu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end
  end

endmodule

@@ sv/mbrtu_front.sv @@
module mbrtu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  mbrtu_pkg::cfg_t     cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_adc_channel,
  input  logic [9:0]          in_adc_sample,
  output logic                push,
  output mbrtu_pkg::job_t     push_job,
  input  logic                q_full
);

  logic [mbrtu_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic [9:0]  sub_r, sub_nxt;
  logic [mbrtu_pkg::SEC_W-1:0] sec_r, sec_nxt;
  logic [9:0]  s0_r, s0_nxt, s1_r, s1_nxt;
  logic        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    len_nxt  = len_r;
    idle_nxt = idle_r;
    ms_nxt   = ms_r;
    sub_nxt  = sub_r;
    sec_nxt  = sec_r;
    s0_nxt   = s0_r;
    s1_nxt   = s1_r;
    push     = 1'b0;
    push_job.op      = mbrtu_pkg::OP_BYTE;
    push_job.wr_addr = len_r[mbrtu_pkg::ADDR_W-1:0];
    push_job.data    = in_rx_byte;
    push_job.len     = len_r;
    push_job.seconds = '0;
    push_job.sample0 = s0_r;
    push_job.sample1 = s1_r;
    if (acc) begin
      case (in_kind)
        mbrtu_pkg::KIND_BYTE: begin
          // drop bytes past capacity, still restart the silence count
          if (len_r < mbrtu_pkg::LEN_W'(mbrtu_pkg::FRAME_BYTES)) begin
            push    = 1'b1;
            len_nxt = len_r + 1'b1;
          end
          idle_nxt = '0;
        end
        mbrtu_pkg::KIND_TICK: begin
          ms_nxt = ms_r + 32'd1;
          // seconds track ms/1000, so both restart when ms wraps
          if (ms_r == 32'hFFFF_FFFF) begin
            sub_nxt = '0;
            sec_nxt = '0;
          end else if (sub_r == mbrtu_pkg::MS_PER_SEC_M1) begin
            sub_nxt = '0;
            sec_nxt = sec_r + 1'b1;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
          if (len_r != '0) begin
            if (idle_r >= cfg.silence) begin
              push             = 1'b1;
              push_job.op      = mbrtu_pkg::OP_FRAME;
              push_job.seconds = sec_nxt[15:0];
              len_nxt          = '0;
              idle_nxt         = '0;
            end else begin
              idle_nxt = idle_r + 8'd1;
            end
          end
        end
        mbrtu_pkg::KIND_SAMPLE: begin
          if (in_adc_channel) begin
            s1_nxt = in_adc_sample;
          end else begin
            s0_nxt = in_adc_sample;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      idle_r <= '0;
      ms_r   <= '0;
      sub_r  <= '0;
      sec_r  <= '0;
      s0_r   <= '0;
      s1_r   <= '0;
    end else begin
      len_r  <= len_nxt;
      idle_r <= idle_nxt;
      ms_r   <= ms_nxt;
      sub_r  <= sub_nxt;
      sec_r  <= sec_nxt;
      s0_r   <= s0_nxt;
      s1_r   <= s1_nxt;
    end
  end

endmodule

@@ sv/mbrtu_back.sv @@
module mbrtu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mbrtu_pkg::cfg_t    cfg,
  input  logic               q_empty,
  input  mbrtu_pkg::job_t    pop_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [7:0]         out_tx_byte,
  output logic               out_last
);

  localparam int AW = mbrtu_pkg::ADDR_W;
  localparam int LW = mbrtu_pkg::LEN_W;
  localparam int DW = mbrtu_pkg::DIV_W;

  logic [7:0] mem [mbrtu_pkg::FRAME_BYTES];
  logic [7:0] rd_data_r;

  mbrtu_pkg::back_state_t state_r, state_nxt;
  logic [LW-1:0] idx_r, idx_nxt, len_r, len_nxt;
  logic [15:0] sec_r, sec_nxt;
  logic [9:0]  s0_r, s0_nxt, s1_r, s1_nxt;
  logic [7:0]  hdr_r [6];
  logic [15:0] crc_r, crc_nxt, rxcrc_r, rxcrc_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        ch_r, ch_nxt;
  logic [15:0] mv0_r, mv0_nxt, mv1_r, mv1_nxt;
  logic [4:0]  k_r, k_nxt;
  logic        ov_r, ov_nxt, last_r, last_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  logic [7:0]  otx_r, otx_nxt;

  logic        out_free, hdr_we, mem_we;
  logic [15:0] start_w, qty_w, reg_w;
  logic [16:0] span_w;
  logic [4:0]  total_w, j_w;
  logic [2:0]  ri_w;
  logic [7:0]  byte_w;
  logic [DW:0] est_w;
  logic [DW-1:0] back_w, diff_w;

  assign out_free = !ov_r || out_ready;
  assign start_w  = {hdr_r[2], hdr_r[3]};
  assign qty_w    = {hdr_r[4], hdr_r[5]};
  assign span_w   = {1'b0, start_w} + {1'b0, qty_w};
  assign total_w  = 5'd5 + {1'b0, qty_w[2:0], 1'b0};
  assign j_w      = k_r - 5'd3;
  assign ri_w     = start_w[2:0] + j_w[3:1];
  // x/1023 ~ x*(1 + 2^-10 + 2^-20)/1024, low by at most one
  assign est_w    = (DW+1)'(div_r) + (DW+1)'(div_r >> 10) + (DW+1)'(div_r >> 20);
  assign back_w   = DW'({quo_r, 10'd0}) - DW'(quo_r);
  assign diff_w   = div_r - back_w;

  always_comb begin
    case (ri_w)
      3'd0:    reg_w = {6'd0, s0_r};
      3'd1:    reg_w = {6'd0, s1_r};
      3'd2:    reg_w = mv0_r;
      3'd3:    reg_w = mv1_r;
      3'd4:    reg_w = sec_r;
      default: reg_w = cfg.vref;
    endcase
  end

  always_comb begin
    if (k_r == 5'd0) begin
      byte_w = cfg.slave_addr;
    end else if (k_r == 5'd1) begin
      byte_w = mbrtu_pkg::FN_READ_HOLDING;
    end else if (k_r == 5'd2) begin
      byte_w = {qty_w[6:0], 1'b0};
    end else if (k_r == total_w - 5'd2) begin
      byte_w = crc_r[7:0];
    end else if (k_r == total_w - 5'd1) begin
      byte_w = crc_r[15:8];
    end else begin
      byte_w = j_w[0] ? reg_w[7:0] : reg_w[15:8];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbrtu_pkg::B_IDLE: begin
        if (!q_empty && pop_job.op == mbrtu_pkg::OP_FRAME) begin
          state_nxt = (pop_job.len < mbrtu_pkg::MIN_FRAME) ? mbrtu_pkg::B_STAT
                                                            : mbrtu_pkg::B_READ;
        end
      end
      mbrtu_pkg::B_READ: state_nxt = mbrtu_pkg::B_WAIT;
      mbrtu_pkg::B_WAIT: begin
        state_nxt = (idx_r == len_r - 1'b1) ? mbrtu_pkg::B_CHECK : mbrtu_pkg::B_READ;
      end
      mbrtu_pkg::B_CHECK: begin
        if (hdr_r[0] != cfg.slave_addr || crc_r != rxcrc_r
            || hdr_r[1] != mbrtu_pkg::FN_READ_HOLDING || len_r != mbrtu_pkg::REQ_LEN
            || span_w > mbrtu_pkg::NUM_REGS) begin
          state_nxt = mbrtu_pkg::B_STAT;
        end else begin
          state_nxt = mbrtu_pkg::B_DIV;
        end
      end
      mbrtu_pkg::B_DIV: begin
        if (cnt_r == 5'd2 && ch_r) begin
          state_nxt = mbrtu_pkg::B_EMIT;
        end
      end
      mbrtu_pkg::B_EMIT: begin
        if (out_free && k_r == total_w - 5'd1) begin
          state_nxt = mbrtu_pkg::B_IDLE;
        end
      end
      mbrtu_pkg::B_STAT: begin
        if (out_free) begin
          state_nxt = mbrtu_pkg::B_IDLE;
        end
      end
      default: state_nxt = mbrtu_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    hdr_we    = 1'b0;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    sec_nxt   = sec_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    crc_nxt   = crc_r;
    rxcrc_nxt = rxcrc_r;
    stat_nxt  = stat_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    ch_nxt    = ch_r;
    mv0_nxt   = mv0_r;
    mv1_nxt   = mv1_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && !out_ready;
    ostat_nxt = ostat_r;
    otx_nxt   = otx_r;
    last_nxt  = last_r;
    case (state_r)
      mbrtu_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (pop_job.op == mbrtu_pkg::OP_BYTE) begin
            mem_we = 1'b1;
          end else begin
            len_nxt  = pop_job.len;
            sec_nxt  = pop_job.seconds;
            s0_nxt   = pop_job.sample0;
            s1_nxt   = pop_job.sample1;
            idx_nxt  = '0;
            crc_nxt  = mbrtu_pkg::CRC_INIT;
            stat_nxt = mbrtu_pkg::ST_SHORT;
          end
        end
      end
      mbrtu_pkg::B_READ: begin
      end
      mbrtu_pkg::B_WAIT: begin
        hdr_we = (idx_r < mbrtu_pkg::MIN_FRAME);
        if (idx_r < len_r - LW'(2)) begin
          crc_nxt = mbrtu_pkg::crc_byte(crc_r, rd_data_r);
        end else if (idx_r == len_r - LW'(2)) begin
          rxcrc_nxt[7:0] = rd_data_r;
        end else begin
          rxcrc_nxt[15:8] = rd_data_r;
        end
        idx_nxt = idx_r + 1'b1;
      end
      mbrtu_pkg::B_CHECK: begin
        if (hdr_r[0] != cfg.slave_addr) begin
          stat_nxt = mbrtu_pkg::ST_ADDR;
        end else if (crc_r != rxcrc_r) begin
          stat_nxt = mbrtu_pkg::ST_CRC;
        end else if (hdr_r[1] != mbrtu_pkg::FN_READ_HOLDING || len_r != mbrtu_pkg::REQ_LEN) begin
          stat_nxt = mbrtu_pkg::ST_UNSUP;
        end else begin
          stat_nxt = mbrtu_pkg::ST_RANGE;
        end
        div_nxt = DW'(s0_r) * DW'(cfg.vref);
        rem_nxt = '0;
        cnt_nxt = '0;
        ch_nxt  = 1'b0;
      end
      mbrtu_pkg::B_DIV: begin
        // divide by 1023 in three steps: estimate, remainder, correct
        cnt_nxt = cnt_r + 5'd1;
        case (cnt_r)
          5'd0: quo_nxt = est_w[DW-1:10];
          5'd1: rem_nxt = diff_w[10:0];
          default: begin
            quo_nxt = (rem_r >= mbrtu_pkg::ADC_FULL) ? quo_r + 16'd1 : quo_r;
            if (!ch_r) begin
              mv0_nxt = quo_nxt;
              div_nxt = DW'(s1_r) * DW'(cfg.vref);
              rem_nxt = '0;
              cnt_nxt = '0;
              ch_nxt  = 1'b1;
            end else begin
              mv1_nxt = quo_nxt;
              k_nxt   = '0;
              crc_nxt = mbrtu_pkg::CRC_INIT;
            end
          end
        endcase
      end
      mbrtu_pkg::B_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ostat_nxt = mbrtu_pkg::ST_RESP;
          otx_nxt   = byte_w;
          last_nxt  = (k_r == total_w - 5'd1);
          if (k_r < total_w - 5'd2) begin
            crc_nxt = mbrtu_pkg::crc_byte(crc_r, byte_w);
          end
          k_nxt = k_r + 5'd1;
        end
      end
      mbrtu_pkg::B_STAT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ostat_nxt = stat_r;
          otx_nxt   = '0;
          last_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pop_job.wr_addr] <= pop_job.data;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
    if (hdr_we) begin
      hdr_r[idx_r[2:0]] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    len_r   <= len_nxt;
    sec_r   <= sec_nxt;
    s0_r    <= s0_nxt;
    s1_r    <= s1_nxt;
    crc_r   <= crc_nxt;
    rxcrc_r <= rxcrc_nxt;
    stat_r  <= stat_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    ch_r    <= ch_nxt;
    mv0_r   <= mv0_nxt;
    mv1_r   <= mv1_nxt;
    k_r     <= k_nxt;
    ostat_r <= ostat_nxt;
    otx_r   <= otx_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbrtu_pkg::B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_status  = ostat_r;
  assign out_tx_byte = otx_r;
  assign out_last    = last_r;

`ifndef SYNTHESIS
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ostat_r != mbrtu_pkg::ST_RESP |-> last_r)
    else $error("status transaction without last");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ostat_r != mbrtu_pkg::ST_RESP |-> otx_r == 8'd0)
    else $error("status transaction carries a byte");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mbrtu_pkg::B_EMIT |-> k_r < total_w)
    else $error("response index past frame end");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != mbrtu_pkg::B_IDLE |-> !pop)
    else $error("queue popped while a frame is in work");
`endif

endmodule

@@ sv/modbus_rtu_read_slave_top.sv @@
// Modbus RTU slave answering read holding registers (function 3).
// Input channel (in_valid/in_ready): kind 0 carries a received byte,
// kind 1 a 1 ms tick, kind 2 an ADC sample for one channel. Each input
// transaction is taken in one cycle while the two-entry job queue has room.
// A tick after at least silence idle ticks ends the frame; the
// frame job then runs in the back end: a read and a wait state per stored
// byte for the CRC walk, a check state, the two millivolt divides
// (3 steps each), then one result byte per cycle while the receiver
// takes them. A request gives up to 17 response transactions
// (status 0, last on the final one); a rejected frame gives
// one status transaction instead. Bytes and samples keep flowing in
// while the back end works, until the queue fills.
// Output channel (out_valid/out_ready) holds its result while the
// receiver stalls; the back end waits, then the queue fills and in_ready
// drops. Reset clears frame length, counters, samples and configuration
// (address 1, silence 4, vref 5000). APB registers at 0x0, 0x4, 0x8.
module modbus_rtu_read_slave_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mbrtu_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_adc_channel,
  input  logic [9:0]  in_adc_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_tx_byte,
  output logic        out_last
);

  mbrtu_pkg::cfg_t cfg_r;
  mbrtu_pkg::job_t push_job, pop_job;
  logic push, pop, q_full, q_empty, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_addr <= mbrtu_pkg::RST_SLAVE;
      cfg_r.silence    <= mbrtu_pkg::RST_SILENCE;
      cfg_r.vref       <= mbrtu_pkg::RST_VREF;
    end else if (wr_en) begin
      case (paddr[3:2])
        mbrtu_pkg::REG_SLAVE:   cfg_r.slave_addr <= pwdata[7:0];
        mbrtu_pkg::REG_SILENCE: cfg_r.silence    <= pwdata[7:0];
        mbrtu_pkg::REG_VREF:    cfg_r.vref       <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mbrtu_pkg::REG_SLAVE:   prdata = {24'd0, cfg_r.slave_addr};
      mbrtu_pkg::REG_SILENCE: prdata = {24'd0, cfg_r.silence};
      mbrtu_pkg::REG_VREF:    prdata = {16'd0, cfg_r.vref};
      default:                prdata = '0;
    endcase
  end

  mbrtu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .in_adc_channel (in_adc_channel),
    .in_adc_sample  (in_adc_sample),
    .push           (push),
    .push_job       (push_job),
    .q_full         (q_full)
  );

  mbrtu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  mbrtu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last)
  );

endmodule

@@ verif/tb_modbus_rtu_read_slave_top.sv @@
module tb_modbus_rtu_read_slave_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         IDLE_LIMIT  = 4000;
  localparam int         SETTLE_CYC  = 300;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] tx_byte;
    logic       last;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [7:0]  in_rx_byte;
  logic        in_adc_channel;
  logic [9:0]  in_adc_sample;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_tx_byte;
  logic        out_last;

  modbus_rtu_read_slave_top i_dut (.*);

  // slave state as seen from outside
  logic [7:0]  slave_addr_q;
  logic [7:0]  silence_q;
  logic [15:0] vref_q;
  logic [7:0]  rx_frame[$];
  logic [7:0]  idle_ticks;
  logic [31:0] ms_count;
  logic [9:0]  adc0;
  logic [9:0]  adc1;

  reply_t      pending_replies[$];
  int          idle_pct;
  int          stall_pct;
  int          mismatches;
  int          items_sent;
  int          responses_seen;
  int          rejects_seen;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] modbus_crc(input logic [7:0] bytes[$]);
    logic [15:0] c;
    c = mbrtu_pkg::CRC_INIT;
    foreach (bytes[i]) begin
      c ^= {8'h00, bytes[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ mbrtu_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_reject(input logic [2:0] code);
    pending_replies.push_back('{status: code, tx_byte: 8'h00, last: 1'b1});
  endfunction

  // answer the collected frame the way the slave should
  function automatic void answer_frame();
    logic [7:0]  resp[$];
    logic [15:0] regs[6];
    logic [15:0] c;
    int          n;
    int          first;
    int          count;
    n = rx_frame.size();
    if (n < 6) begin
      push_reject(mbrtu_pkg::ST_SHORT);
      return;
    end
    if (rx_frame[0] != slave_addr_q) begin
      push_reject(mbrtu_pkg::ST_ADDR);
      return;
    end
    resp = rx_frame[0:n-3];
    if (modbus_crc(resp) != {rx_frame[n-1], rx_frame[n-2]}) begin
      push_reject(mbrtu_pkg::ST_CRC);
      return;
    end
    if (rx_frame[1] != mbrtu_pkg::FN_READ_HOLDING || n != 8) begin
      push_reject(mbrtu_pkg::ST_UNSUP);
      return;
    end
    first = int'({rx_frame[2], rx_frame[3]});
    count = int'({rx_frame[4], rx_frame[5]});
    if (first + count > 6) begin
      push_reject(mbrtu_pkg::ST_RANGE);
      return;
    end
    regs[0] = 16'(adc0);
    regs[1] = 16'(adc1);
    regs[2] = 16'((32'(adc0) * 32'(vref_q)) / 1023);
    regs[3] = 16'((32'(adc1) * 32'(vref_q)) / 1023);
    regs[4] = 16'(ms_count / 1000);
    regs[5] = vref_q;
    resp = '{slave_addr_q, mbrtu_pkg::FN_READ_HOLDING, 8'(count * 2)};
    for (int i = 0; i < count; i++) begin
      resp.push_back(regs[first + i][15:8]);
      resp.push_back(regs[first + i][7:0]);
    end
    c = modbus_crc(resp);
    resp.push_back(c[7:0]);
    resp.push_back(c[15:8]);
    foreach (resp[i])
      pending_replies.push_back('{status: mbrtu_pkg::ST_RESP, tx_byte: resp[i],
                                  last: (i == resp.size() - 1)});
  endfunction

  function automatic void track_item(input logic [1:0] kind, input logic [7:0] rx,
                                     input logic ch, input logic [9:0] smp);
    case (kind)
      mbrtu_pkg::KIND_BYTE: begin
        if (rx_frame.size() < mbrtu_pkg::FRAME_BYTES) rx_frame.push_back(rx);
        idle_ticks = 8'd0;
      end
      mbrtu_pkg::KIND_TICK: begin
        ms_count++;
        if (rx_frame.size() > 0) begin
          if (idle_ticks >= silence_q) begin
            answer_frame();
            rx_frame.delete();
            idle_ticks = 8'd0;
          end else begin
            idle_ticks++;
          end
        end
      end
      mbrtu_pkg::KIND_SAMPLE: begin
        if (ch) adc1 = smp;
        else adc0 = smp;
      end
      default: ;
    endcase
  endfunction

  // call at a rising edge; leaves valid high after the transaction
  task automatic send_item(input logic [1:0] kind, input logic [7:0] rx = 8'h00,
                           input logic ch = 1'b0, input logic [9:0] smp = 10'd0);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_kind        <= 2'($urandom);
      in_rx_byte     <= 8'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_rx_byte     <= rx;
    in_adc_channel <= ch;
    in_adc_sample  <= smp;
    do @(posedge clk); while (!in_ready);
    track_item(kind, rx, ch, smp);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(mbrtu_pkg::KIND_TICK);
  endtask

  task automatic send_sample(input logic ch, input logic [9:0] smp);
    send_item(mbrtu_pkg::KIND_SAMPLE, 8'h00, ch, smp);
  endtask

  // bytes, the odd sample in between, then enough ticks to close the frame
  task automatic send_frame(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      if ($urandom_range(9) == 0) send_sample(1'($urandom), 10'($urandom));
      send_item(mbrtu_pkg::KIND_BYTE, bytes[i]);
    end
    send_ticks(int'(silence_q) + 1);
  endtask

  function automatic void build_request(output logic [7:0] bytes[$], input logic [7:0] addr,
                                        input logic [7:0] fn, input logic [15:0] first,
                                        input logic [15:0] count);
    logic [15:0] c;
    bytes = '{addr, fn, first[15:8], first[7:0], count[15:8], count[7:0]};
    c = modbus_crc(bytes);
    bytes.push_back(c[7:0]);
    bytes.push_back(c[15:8]);
  endfunction

  task automatic send_request(input logic [15:0] first, input logic [15:0] count);
    logic [7:0] bytes[$];
    build_request(bytes, slave_addr_q, mbrtu_pkg::FN_READ_HOLDING, first, count);
    send_frame(bytes);
  endtask

  // drop valid, wait for every reply, then let the back end settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mbrtu_pkg::REG_SLAVE:   slave_addr_q = value[7:0];
      mbrtu_pkg::REG_SILENCE: silence_q    = value[7:0];
      mbrtu_pkg::REG_VREF:    vref_q       = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_idling(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task automatic test_default_reads();
    send_sample(1'b0, 10'd1023);
    send_sample(1'b1, 10'd0);
    send_request(16'd0, 16'd6);
    send_sample(1'b1, 10'd1023);
    send_sample(1'b0, 10'd0);
    send_request(16'd5, 16'd1);
    // zero quantity still gets a header and CRC
    send_request(16'd3, 16'd0);
    drain();
  endtask

  task automatic test_rejects();
    logic [7:0] bytes[$];
    // a short silence keeps the frame count high for few transactions
    write_reg(mbrtu_pkg::REG_SILENCE, 32'd1);
    bytes = '{slave_addr_q, mbrtu_pkg::FN_READ_HOLDING, 8'h00, 8'h00, 8'h01};
    send_frame(bytes);
    build_request(bytes, slave_addr_q + 8'd1, mbrtu_pkg::FN_READ_HOLDING, 16'd0, 16'd1);
    send_frame(bytes);
    build_request(bytes, slave_addr_q, mbrtu_pkg::FN_READ_HOLDING, 16'd0, 16'd1);
    bytes[7] ^= 8'h80;
    send_frame(bytes);
    build_request(bytes, slave_addr_q, 8'h04, 16'd0, 16'd1);
    send_frame(bytes);
    // well-formed CRC but one byte too many
    bytes = '{slave_addr_q, mbrtu_pkg::FN_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55};
    begin
      logic [15:0] c;
      c = modbus_crc(bytes);
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
    end
    send_frame(bytes);
    send_request(16'd6, 16'd1);
    send_request(16'hFFFF, 16'hFFFF);
    send_item(KIND_UNUSED, 8'hFF, 1'b1, 10'h3FF);
    // overflow: bytes past the store are dropped
    bytes.delete();
    repeat (mbrtu_pkg::FRAME_BYTES + 2) bytes.push_back(8'($urandom));
    send_frame(bytes);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(mbrtu_pkg::REG_SLAVE, 32'hFF);
    write_reg(mbrtu_pkg::REG_SILENCE, 32'd1);
    write_reg(mbrtu_pkg::REG_VREF, 32'hFFFF);
    send_sample(1'b0, 10'd1023);
    send_sample(1'b1, 10'd512);
    send_request(16'd0, 16'd6);
    drain();
    write_reg(mbrtu_pkg::REG_SLAVE, 32'h00);
    write_reg(mbrtu_pkg::REG_SILENCE, 32'd8);
    write_reg(mbrtu_pkg::REG_VREF, 32'h0);
    send_request(16'd2, 16'd4);
    drain();
  endtask

  task automatic send_random_frame();
    logic [7:0] bytes[$];
    int         pick;
    int         first;
    pick  = $urandom_range(99);
    first = $urandom_range(6);
    build_request(bytes, slave_addr_q, mbrtu_pkg::FN_READ_HOLDING, 16'(first),
                  16'($urandom_range(6 - first)));
    if (pick < 60) begin
      send_frame(bytes);
      return;
    end
    if (pick < 66) bytes[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
    else if (pick < 72)
      build_request(bytes, 8'($urandom), mbrtu_pkg::FN_READ_HOLDING, 16'(first), 16'd1);
    else if (pick < 78) build_request(bytes, slave_addr_q, 8'($urandom), 16'(first), 16'd1);
    else if (pick < 84)
      build_request(bytes, slave_addr_q, mbrtu_pkg::FN_READ_HOLDING, 16'($urandom),
                    16'($urandom));
    else if (pick < 90) bytes = bytes[0:$urandom_range(4)];
    else begin
      bytes.delete();
      repeat ((pick == 99) ? mbrtu_pkg::FRAME_BYTES + 2 : $urandom_range(6, 12))
        bytes.push_back(8'($urandom));
      if ($urandom_range(1)) bytes[0] = slave_addr_q;
    end
    send_frame(bytes);
  endtask

  task automatic test_random_traffic(input int target);
    while (items_sent < target) begin
      case ($urandom_range(9))
        0: send_sample(1'($urandom), 10'($urandom));
        1: send_ticks($urandom_range(1, 3));
        2: send_item(KIND_UNUSED, 8'($urandom), 1'($urandom), 10'($urandom));
        default: send_random_frame();
      endcase
    end
    drain();
  endtask

  task automatic random_config();
    write_reg(mbrtu_pkg::REG_SLAVE, $urandom_range(255));
    write_reg(mbrtu_pkg::REG_SILENCE, $urandom_range(1, 3));
    write_reg(mbrtu_pkg::REG_VREF, $urandom_range(65535));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: status %0d byte %02h last %0b",
                   out_status, out_tx_byte, out_last);
      end else begin
        exp_r = pending_replies.pop_front();
        if (exp_r.status == mbrtu_pkg::ST_RESP && exp_r.last) responses_seen++;
        if (exp_r.status != mbrtu_pkg::ST_RESP) rejects_seen++;
        if (out_status !== exp_r.status || out_tx_byte !== exp_r.tx_byte ||
            out_last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d byte %02h last %0b, got %0d %02h %0b",
                     exp_r.status, exp_r.tx_byte, exp_r.last,
                     out_status, out_tx_byte, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid       <= 1'b0;
    in_kind        <= mbrtu_pkg::KIND_BYTE;
    in_rx_byte     <= '0;
    in_adc_channel <= 1'b0;
    in_adc_sample  <= '0;
    quiet_cycles   = 0;
    mismatches     = 0;
    items_sent     = 0;
    responses_seen = 0;
    rejects_seen   = 0;
    slave_addr_q   = mbrtu_pkg::RST_SLAVE;
    silence_q      = mbrtu_pkg::RST_SILENCE;
    vref_q         = mbrtu_pkg::RST_VREF;
    idle_ticks     = 8'd0;
    ms_count       = 32'd0;
    adc0           = 10'd0;
    adc1           = 10'd0;
    set_idling(0, 0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_reads();
    set_idling(56, 0);
    test_rejects();
    set_idling(0, 56);
    test_config_extremes();
    set_idling(0, 0);
    random_config();
    test_random_traffic(items_sent + 12);
    set_idling(56, 0);
    random_config();
    test_random_traffic(items_sent + 12);
    set_idling(0, 56);
    random_config();
    test_random_traffic(items_sent + 12);
    set_idling(27, 27);
    random_config();
    test_random_traffic(items_sent + 12);

    $display("Sent %0d input transactions; %0d frames answered, %0d frames rejected.",
             items_sent, responses_seen, rejects_seen);
    $display("Configurations covered reset values, extreme address and reference values "
             , "and random settings.");
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
